### hdl/eal_pkg.sv
// eal_pkg: shared types and constants for the edit alignment label generator
// depends on nothing; used by eal_ctrl, eal_dp and edit_alignment_label_gen
package eal_pkg;

    localparam int MAX_LEN = 63;
    localparam int IDX_W   = 6;
    localparam int TOK_W   = 32;
    localparam int CST_W   = 6;
    localparam int CFG_W   = 2;

    typedef enum logic [1:0] {
        CMD_NOISY = 2'd0,
        CMD_CLEAN = 2'd1,
        CMD_RUN   = 2'd2
    } cmd_code_t;

    typedef enum logic [CFG_W-1:0] {
        REG_DELETE = 2'd0,
        REG_END    = 2'd1,
        REG_IGNORE = 2'd2,
        REG_KEEP   = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROW0,
        ST_ROW_RD,
        ST_ROW_LAT,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_TB_CHK,
        ST_TB_RD1,
        ST_TB_RD2,
        ST_TB_DEC,
        ST_ND_RD,
        ST_ND_WR,
        ST_FX_RD1,
        ST_FX_RD2,
        ST_FX_SW,
        ST_FX_SW2,
        ST_FX_FRD,
        ST_FX_FIL,
        ST_FX_LAST,
        ST_FX_LWR,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT
    } state_t;

    typedef struct packed {
        state_t op;
    } ctrl_t;

    typedef struct packed {
        logic run_cmd;
        logic n_zero;
        logic m_zero;
        logic i_last;
        logic j_last;
        logic k_last;
        logic k_zero;
        logic k_fx_last;
        logic tb_done;
        logic swap;
        logic out_done;
        logic out_last;
    } stat_t;

endpackage

### hdl/eal_ctrl.sv
// eal_ctrl: sequencer for table fill, traceback, label passes and result output
// depends on eal_pkg (state_t, ctrl_t, stat_t)
module eal_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  eal_pkg::stat_t stat,
    output eal_pkg::ctrl_t ctrl
);

    eal_pkg::state_t state_reg;
    eal_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eal_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = state_reg;
        case (state_reg)
            eal_pkg::ST_IDLE:
            begin
                if (stat.run_cmd)
                    state_next = eal_pkg::ST_ROW0;
            end
            eal_pkg::ST_ROW0:
            begin
                if (stat.j_last)
                    state_next = stat.n_zero ? eal_pkg::ST_INIT_RD : eal_pkg::ST_ROW_RD;
            end
            eal_pkg::ST_ROW_RD:  state_next = eal_pkg::ST_ROW_LAT;
            eal_pkg::ST_ROW_LAT:
            begin
                if (!stat.m_zero)
                    state_next = eal_pkg::ST_CELL_RD;
                else if (stat.i_last)
                    state_next = eal_pkg::ST_INIT_RD;
                else
                    state_next = eal_pkg::ST_ROW_RD;
            end
            eal_pkg::ST_CELL_RD: state_next = eal_pkg::ST_CELL_WR;
            eal_pkg::ST_CELL_WR:
            begin
                if (!stat.j_last)
                    state_next = eal_pkg::ST_CELL_RD;
                else if (stat.i_last)
                    state_next = eal_pkg::ST_INIT_RD;
                else
                    state_next = eal_pkg::ST_ROW_RD;
            end
            eal_pkg::ST_INIT_RD: state_next = eal_pkg::ST_INIT_WR;
            eal_pkg::ST_INIT_WR:
            begin
                state_next = stat.k_last ? eal_pkg::ST_TB_CHK : eal_pkg::ST_INIT_RD;
            end
            eal_pkg::ST_TB_CHK:
            begin
                if (!stat.tb_done)
                    state_next = eal_pkg::ST_TB_RD1;
                else
                    state_next = stat.n_zero ? eal_pkg::ST_FX_LAST : eal_pkg::ST_ND_RD;
            end
            eal_pkg::ST_TB_RD1:  state_next = eal_pkg::ST_TB_RD2;
            eal_pkg::ST_TB_RD2:  state_next = eal_pkg::ST_TB_DEC;
            eal_pkg::ST_TB_DEC:  state_next = eal_pkg::ST_TB_CHK;
            eal_pkg::ST_ND_RD:   state_next = eal_pkg::ST_ND_WR;
            eal_pkg::ST_ND_WR:
            begin
                state_next = stat.k_zero ? eal_pkg::ST_FX_RD1 : eal_pkg::ST_ND_RD;
            end
            eal_pkg::ST_FX_RD1:  state_next = eal_pkg::ST_FX_RD2;
            eal_pkg::ST_FX_RD2:  state_next = eal_pkg::ST_FX_SW;
            eal_pkg::ST_FX_SW:
            begin
                state_next = stat.swap ? eal_pkg::ST_FX_SW2 : eal_pkg::ST_FX_FRD;
            end
            eal_pkg::ST_FX_SW2:  state_next = eal_pkg::ST_FX_FRD;
            eal_pkg::ST_FX_FRD:  state_next = eal_pkg::ST_FX_FIL;
            eal_pkg::ST_FX_FIL:
            begin
                state_next = stat.k_fx_last ? eal_pkg::ST_FX_LAST : eal_pkg::ST_FX_RD1;
            end
            eal_pkg::ST_FX_LAST: state_next = eal_pkg::ST_FX_LWR;
            eal_pkg::ST_FX_LWR:  state_next = eal_pkg::ST_EM_RD;
            eal_pkg::ST_EM_RD:   state_next = eal_pkg::ST_EM_LD;
            eal_pkg::ST_EM_LD:   state_next = eal_pkg::ST_EM_WAIT;
            eal_pkg::ST_EM_WAIT:
            begin
                if (stat.out_done)
                    state_next = stat.out_last ? eal_pkg::ST_IDLE : eal_pkg::ST_EM_RD;
            end
            default:             state_next = eal_pkg::ST_IDLE;
        endcase
    end

endmodule

### hdl/eal_dp.sv
// eal_dp: token stores, cost table, label stores, counters and output register
// depends on eal_pkg; driven by the op code from eal_ctrl
module eal_dp #(
    parameter int MAX_LEN = eal_pkg::MAX_LEN
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  eal_pkg::ctrl_t                 ctrl,
    output eal_pkg::stat_t                 stat,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     command,
    input  logic signed [eal_pkg::TOK_W-1:0] token,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [eal_pkg::IDX_W-1:0]      position,
    output logic                           has_token_label,
    output logic signed [eal_pkg::TOK_W-1:0] token_label,
    output logic signed [eal_pkg::TOK_W-1:0] next_label,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [eal_pkg::CFG_W-1:0]      cfg_index,
    input  logic signed [eal_pkg::TOK_W-1:0] cfg_data
);

    localparam int IW = eal_pkg::IDX_W;
    localparam int TW = eal_pkg::TOK_W;
    localparam int CW = eal_pkg::CST_W;
    localparam int COST_DEPTH = 2 ** (2 * IW);

    // stores
    logic [TW-1:0] noisy_mem [0:MAX_LEN-1];
    logic [TW-1:0] clean_mem [0:MAX_LEN-1];
    logic [TW-1:0] tlab_mem  [0:MAX_LEN-1];
    logic [TW-1:0] nd_mem    [0:MAX_LEN-1];
    logic [TW-1:0] nlab_mem  [0:MAX_LEN];
    logic [CW-1:0] cost_mem  [0:COST_DEPTH-1];

    logic [TW-1:0] noisy_q, clean_q, tlab_q, nd_q, nlab_q;
    logic [CW-1:0] cost_q;

    // config
    logic [TW-1:0] del_reg, end_reg, ign_reg;
    logic          keep_reg;

    // control state
    logic [IW-1:0] n_len_reg, m_len_reg, i_reg, j_reg, k_reg;
    logic [IW-1:0] n_len_next, m_len_next, i_next, j_next, k_next;
    logic          ov_reg, ov_next;

    // payload
    logic [CW-1:0] left_reg, left_next, diag_reg, diag_next, c_reg, c_next, d_reg, d_next;
    logic [TW-1:0] nrow_reg, nrow_next, nv_reg, nv_next, cv_reg, cv_next;
    logic [TW-1:0] a_reg, a_next, b_reg, b_next, ndr_reg, ndr_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic          has_reg, has_next, last_reg, last_next;
    logic [TW-1:0] tl_reg, tl_next, nl_reg, nl_next;

    // ports of the memories
    logic [IW-1:0]   noisy_ra, clean_ra, tlab_ra, nlab_ra, nd_ra;
    logic [2*IW-1:0] cost_ra, cost_wa;
    logic            cost_we, tlab_we, nlab_we, nd_we, noisy_we, clean_we;
    logic [CW-1:0]   cost_wd;
    logic [IW-1:0]   tlab_wa, nlab_wa, nd_wa;
    logic [TW-1:0]   tlab_wd, nlab_wd, nd_wd;

    logic          in_fire;
    logic [IW-1:0] im1, jm1, km1, kp1, kp2;
    logic [CW:0]   dg, up1, lf1, mn, cell_val;
    logic          ij_nz, tb_keep, tb_rep, tb_del;
    logic          fill;
    logic [TW-1:0] nd_val;

    assign cfg_ready = 1'b1;
    assign in_stall  = (ctrl.op != eal_pkg::ST_IDLE);
    assign in_fire   = in_valid && !in_stall;

    assign im1 = i_reg - 1'b1;
    assign jm1 = j_reg - 1'b1;
    assign km1 = k_reg - 1'b1;
    assign kp1 = k_reg + 1'b1;
    assign kp2 = k_reg + IW'(2);

    // one table cell: min of diagonal, up and left
    assign dg  = {1'b0, diag_reg} + {{CW{1'b0}}, (nrow_reg != clean_q)};
    assign up1 = {1'b0, cost_q} + 1'b1;
    assign lf1 = {1'b0, left_reg} + 1'b1;
    assign mn  = (dg < up1) ? dg : up1;
    assign cell_val = (mn < lf1) ? mn : lf1;

    // traceback choice, in priority order
    assign ij_nz   = (i_reg != '0) && (j_reg != '0);
    assign tb_keep = ij_nz && (nv_reg == cv_reg) && (c_reg == d_reg);
    assign tb_rep  = ij_nz && ({1'b0, c_reg} == ({1'b0, d_reg} + 1'b1));
    assign tb_del  = (i_reg != '0) && ({1'b0, c_reg} == up1);

    assign fill   = (nlab_q == ign_reg) && ((k_reg == '0) || (tlab_q != del_reg));
    assign nd_val = (tlab_q != del_reg) ? tlab_q : ndr_reg;

    always_comb
    begin
        stat.run_cmd   = in_fire && (command == eal_pkg::CMD_RUN);
        stat.n_zero    = (n_len_reg == '0);
        stat.m_zero    = (m_len_reg == '0);
        stat.i_last    = (i_reg == n_len_reg);
        stat.j_last    = (j_reg == m_len_reg);
        stat.k_last    = (k_reg == n_len_reg);
        stat.k_zero    = (k_reg == '0);
        stat.k_fx_last = ({1'b0, k_reg} + 1'b1 == {1'b0, n_len_reg});
        stat.tb_done   = (i_reg == '0) && (j_reg == '0);
        stat.swap      = ({1'b0, k_reg} + 1'b1 < {1'b0, n_len_reg}) &&
                         (a_reg == b_reg) && (b_reg != ign_reg);
        stat.out_done  = ov_reg && !out_stall;
        stat.out_last  = last_reg;
    end

    // read addresses
    always_comb
    begin
        noisy_ra = k_reg;
        clean_ra = jm1;
        cost_ra  = {im1, j_reg};
        tlab_ra  = k_reg;
        nlab_ra  = k_reg;
        nd_ra    = k_reg;
        case (ctrl.op)
            eal_pkg::ST_ROW_RD:  noisy_ra = im1;
            eal_pkg::ST_TB_CHK:
            begin
                noisy_ra = im1;
                cost_ra  = {i_reg, j_reg};
            end
            eal_pkg::ST_TB_RD1:  cost_ra = {im1, jm1};
            eal_pkg::ST_FX_RD1:
            begin
                tlab_ra = kp1;
                nlab_ra = kp1;
            end
            eal_pkg::ST_FX_RD2:  nlab_ra = kp2;
            eal_pkg::ST_FX_FRD:  tlab_ra = km1;
            eal_pkg::ST_FX_LAST: nlab_ra = n_len_reg;
            default:             noisy_ra = k_reg;
        endcase
    end

    // next state of counters, payload and write ports
    always_comb
    begin
        n_len_next = n_len_reg;
        m_len_next = m_len_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        ov_next = ov_reg;
        left_next = left_reg;
        diag_next = diag_reg;
        c_next = c_reg;
        d_next = d_reg;
        nrow_next = nrow_reg;
        nv_next = nv_reg;
        cv_next = cv_reg;
        a_next = a_reg;
        b_next = b_reg;
        ndr_next = ndr_reg;
        pos_next = pos_reg;
        has_next = has_reg;
        last_next = last_reg;
        tl_next = tl_reg;
        nl_next = nl_reg;
        noisy_we = 1'b0;
        clean_we = 1'b0;
        cost_we = 1'b0;
        cost_wa = {i_reg, j_reg};
        cost_wd = cell_val[CW-1:0];
        tlab_we = 1'b0;
        tlab_wa = k_reg;
        tlab_wd = ign_reg;
        nlab_we = 1'b0;
        nlab_wa = k_reg;
        nlab_wd = ign_reg;
        nd_we = 1'b0;
        nd_wa = k_reg;
        nd_wd = nd_val;
        case (ctrl.op)
            eal_pkg::ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (in_fire && command == eal_pkg::CMD_NOISY &&
                    n_len_reg < IW'(MAX_LEN))
                begin
                    noisy_we = 1'b1;
                    n_len_next = n_len_reg + 1'b1;
                end
                if (in_fire && command == eal_pkg::CMD_CLEAN &&
                    m_len_reg < IW'(MAX_LEN))
                begin
                    clean_we = 1'b1;
                    m_len_next = m_len_reg + 1'b1;
                end
            end
            eal_pkg::ST_ROW0:
            begin
                cost_we = 1'b1;
                cost_wa = {{IW{1'b0}}, j_reg};
                cost_wd = CW'(j_reg);
                if (stat.j_last)
                    i_next = stat.n_zero ? '0 : IW'(1);
                else
                    j_next = j_reg + 1'b1;
            end
            eal_pkg::ST_ROW_RD:
            begin
                cost_we = 1'b1;
                cost_wa = {i_reg, {IW{1'b0}}};
                cost_wd = CW'(i_reg);
                left_next = CW'(i_reg);
                diag_next = CW'(im1);
                j_next = stat.m_zero ? '0 : IW'(1);
            end
            eal_pkg::ST_ROW_LAT:
            begin
                nrow_next = noisy_q;
                if (stat.m_zero && !stat.i_last)
                    i_next = i_reg + 1'b1;
            end
            eal_pkg::ST_CELL_WR:
            begin
                cost_we = 1'b1;
                left_next = cell_val[CW-1:0];
                diag_next = cost_q;
                if (!stat.j_last)
                    j_next = j_reg + 1'b1;
                else if (!stat.i_last)
                    i_next = i_reg + 1'b1;
            end
            eal_pkg::ST_INIT_WR:
            begin
                nlab_we = 1'b1;
                if (!stat.k_last)
                begin
                    tlab_we = 1'b1;
                    tlab_wd = keep_reg ? noisy_q : ign_reg;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    i_next = n_len_reg;
                    j_next = m_len_reg;
                end
            end
            eal_pkg::ST_TB_CHK:
            begin
                if (stat.tb_done)
                begin
                    k_next = n_len_reg - 1'b1;
                    ndr_next = end_reg;
                end
            end
            eal_pkg::ST_TB_RD1:
            begin
                c_next = cost_q;
                nv_next = noisy_q;
                cv_next = clean_q;
            end
            eal_pkg::ST_TB_RD2:  d_next = cost_q;
            eal_pkg::ST_TB_DEC:
            begin
                tlab_wa = im1;
                nlab_wa = i_reg;
                nlab_wd = cv_reg;
                if (tb_keep)
                begin
                    i_next = im1;
                    j_next = jm1;
                end
                else if (tb_rep)
                begin
                    tlab_we = 1'b1;
                    tlab_wd = cv_reg;
                    i_next = im1;
                    j_next = jm1;
                end
                else if (tb_del)
                begin
                    tlab_we = 1'b1;
                    tlab_wd = del_reg;
                    i_next = im1;
                end
                else if (j_reg != '0)
                begin
                    nlab_we = 1'b1;
                    j_next = jm1;
                end
                else
                begin
                    i_next = im1;
                end
            end
            eal_pkg::ST_ND_WR:
            begin
                nd_we = 1'b1;
                ndr_next = nd_val;
                if (!stat.k_zero)
                    k_next = km1;
            end
            eal_pkg::ST_FX_RD2:
            begin
                a_next = tlab_q;
                b_next = nlab_q;
            end
            eal_pkg::ST_FX_SW:
            begin
                nlab_wa = kp1;
                nlab_wd = nlab_q;
                nlab_we = stat.swap;
            end
            eal_pkg::ST_FX_SW2:
            begin
                nlab_we = 1'b1;
                nlab_wa = kp2;
                nlab_wd = b_reg;
            end
            eal_pkg::ST_FX_FIL:
            begin
                nlab_we = fill;
                nlab_wd = nd_q;
                k_next = kp1;
            end
            eal_pkg::ST_FX_LWR:
            begin
                nlab_wa = n_len_reg;
                nlab_wd = end_reg;
                nlab_we = (nlab_q == ign_reg);
                k_next = '0;
            end
            eal_pkg::ST_EM_LD:
            begin
                ov_next = 1'b1;
                pos_next = k_reg;
                has_next = !stat.k_last;
                last_next = stat.k_last;
                tl_next = stat.k_last ? '0 : tlab_q;
                nl_next = nlab_q;
            end
            eal_pkg::ST_EM_WAIT:
            begin
                if (stat.out_done)
                begin
                    ov_next = 1'b0;
                    k_next = kp1;
                    if (last_reg)
                    begin
                        n_len_next = '0;
                        m_len_next = '0;
                    end
                end
            end
            default:
            begin
                ov_next = ov_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_len_reg <= '0;
            m_len_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            ov_reg <= 1'b0;
            del_reg <= 32'hFFFF_FFFF;
            end_reg <= 32'hFFFF_FFFE;
            ign_reg <= 32'hFFFF_FF9C;
            keep_reg <= 1'b0;
        end
        else
        begin
            n_len_reg <= n_len_next;
            m_len_reg <= m_len_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            ov_reg <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    eal_pkg::REG_DELETE: del_reg <= cfg_data;
                    eal_pkg::REG_END:    end_reg <= cfg_data;
                    eal_pkg::REG_IGNORE: ign_reg <= cfg_data;
                    eal_pkg::REG_KEEP:   keep_reg <= cfg_data[0];
                    default:             keep_reg <= keep_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        diag_reg <= diag_next;
        c_reg <= c_next;
        d_reg <= d_next;
        nrow_reg <= nrow_next;
        nv_reg <= nv_next;
        cv_reg <= cv_next;
        a_reg <= a_next;
        b_reg <= b_next;
        ndr_reg <= ndr_next;
        pos_reg <= pos_next;
        has_reg <= has_next;
        last_reg <= last_next;
        tl_reg <= tl_next;
        nl_reg <= nl_next;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (noisy_we)
            noisy_mem[n_len_reg] <= token;
        if (clean_we)
            clean_mem[m_len_reg] <= token;
        if (cost_we)
            cost_mem[cost_wa] <= cost_wd;
        if (tlab_we)
            tlab_mem[tlab_wa] <= tlab_wd;
        if (nlab_we)
            nlab_mem[nlab_wa] <= nlab_wd;
        if (nd_we)
            nd_mem[nd_wa] <= nd_wd;
        noisy_q <= noisy_mem[noisy_ra];
        clean_q <= clean_mem[clean_ra];
        cost_q  <= cost_mem[cost_ra];
        tlab_q  <= tlab_mem[tlab_ra];
        nlab_q  <= nlab_mem[nlab_ra];
        nd_q    <= nd_mem[nd_ra];
    end

    assign out_valid       = ov_reg;
    assign position        = pos_reg;
    assign has_token_label = has_reg;
    assign token_label     = tl_reg;
    assign next_label      = nl_reg;
    assign last            = last_reg;

    a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op != eal_pkg::ST_IDLE) |-> (i_reg <= n_len_reg) && (j_reg <= m_len_reg))
        else $error("traceback or fill left the table");

    a_no_input_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> in_stall)
        else $error("input open while a result word is pending");

    a_cost_row: assert property (@(posedge clk) disable iff (!rst_n)
        cost_we |-> (cost_wa[2*IW-1:IW] <= n_len_reg))
        else $error("cost write beyond noisy length");

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_done && last_reg |=> (n_len_reg == '0) && (m_len_reg == '0))
        else $error("lengths not cleared after final result");

endmodule

### hdl/edit_alignment_label_gen.sv
// edit_alignment_label_gen: top level of the edit alignment label generator
// depends on eal_pkg, eal_ctrl, eal_dp
//
//   channel  | direction | handshake          | word
//   in       | sink      | in_valid/in_stall  | command, token
//   out      | source    | out_valid/out_stall| position, has_token_label,
//            |           |                    | token_label, next_label, last
//   cfg      | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// append words are taken back to back while idle; a run word with n noisy and m
// clean tokens goes through the cost table fill (a read state and a write state
// per cell), label init, traceback (up to n+m steps), the next-token pass and
// the fix-up pass, then emits the result words, which out_stall can hold.
// reset clears lengths and counters and sets the config registers to their defaults;
// stores hold garbage until written. in_stall is high from a run word until the final result word is taken.
module edit_alignment_label_gen #(
    parameter int MAX_LEN = eal_pkg::MAX_LEN
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       command,
    input  logic signed [eal_pkg::TOK_W-1:0] token,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [eal_pkg::IDX_W-1:0]        position,
    output logic                             has_token_label,
    output logic signed [eal_pkg::TOK_W-1:0] token_label,
    output logic signed [eal_pkg::TOK_W-1:0] next_label,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [eal_pkg::CFG_W-1:0]        cfg_index,
    input  logic signed [eal_pkg::TOK_W-1:0] cfg_data
);

    // op code from the sequencer, flags back from the datapath
    eal_pkg::ctrl_t ctrl;
    eal_pkg::stat_t stat;

    eal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    eal_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .token           (token),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .position        (position),
        .has_token_label (has_token_label),
        .token_label     (token_label),
        .next_label      (next_label),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

endmodule

### tb/sv/eal_label_checker.sv
// eal_label_checker: watches the in, out and cfg channels of the edit alignment label generator,
// recomputes the labels of every run and compares each result word; depends on eal_pkg
module eal_label_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [1:0]                       command,
    input  logic signed [eal_pkg::TOK_W-1:0] token,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [eal_pkg::IDX_W-1:0]        position,
    input  logic                             has_token_label,
    input  logic signed [eal_pkg::TOK_W-1:0] token_label,
    input  logic signed [eal_pkg::TOK_W-1:0] next_label,
    input  logic                             last,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [eal_pkg::CFG_W-1:0]        cfg_index,
    input  logic signed [eal_pkg::TOK_W-1:0] cfg_data,
    output int                               fail_count,
    output int                               pending_words,
    output int                               words_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [eal_pkg::IDX_W-1:0] position;
        logic                      has_token_label;
        logic [eal_pkg::TOK_W-1:0] token_label;
        logic [eal_pkg::TOK_W-1:0] next_label;
        logic                      last;
    } label_word_t;

    logic [eal_pkg::TOK_W-1:0] del_lbl, end_lbl, ign_lbl;
    logic                      keep_mode;
    logic [eal_pkg::TOK_W-1:0] noisy_seq[eal_pkg::MAX_LEN];
    logic [eal_pkg::TOK_W-1:0] clean_seq[eal_pkg::MAX_LEN];
    int                        noisy_cnt, clean_cnt;
    label_word_t               label_q[$];

    // edit distance table, traceback and label passes for one run
    task automatic predict_labels();
        int n, m, i, j, k, s;
        int cost[eal_pkg::MAX_LEN+1][eal_pkg::MAX_LEN+1];
        int d;
        logic [eal_pkg::TOK_W-1:0] tl[eal_pkg::MAX_LEN];
        logic [eal_pkg::TOK_W-1:0] nl[eal_pkg::MAX_LEN+1];
        logic [eal_pkg::TOK_W-1:0] a, b, t;
        label_word_t w;
        n = noisy_cnt;
        m = clean_cnt;
        for (i = 0; i <= n; i++) cost[i][0] = i;
        for (j = 0; j <= m; j++) cost[0][j] = j;
        for (i = 1; i <= n; i++)
            for (j = 1; j <= m; j++)
            begin
                d = cost[i-1][j-1] + ((noisy_seq[i-1] == clean_seq[j-1]) ? 0 : 1);
                if (cost[i-1][j] + 1 < d) d = cost[i-1][j] + 1;
                if (cost[i][j-1] + 1 < d) d = cost[i][j-1] + 1;
                cost[i][j] = d;
            end
        for (k = 0; k < n; k++) tl[k] = keep_mode ? noisy_seq[k] : ign_lbl;
        for (k = 0; k <= n; k++) nl[k] = ign_lbl;
        // walk back: keep, replace, delete, insert
        i = n;
        j = m;
        while (i > 0 || j > 0)
        begin
            if (i > 0 && j > 0 && noisy_seq[i-1] == clean_seq[j-1]
                && cost[i][j] == cost[i-1][j-1])
            begin
                i--; j--;
            end
            else if (i > 0 && j > 0 && cost[i][j] == cost[i-1][j-1] + 1)
            begin
                tl[i-1] = clean_seq[j-1];
                i--; j--;
            end
            else if (i > 0 && cost[i][j] == cost[i-1][j] + 1)
            begin
                tl[i-1] = del_lbl;
                i--;
            end
            else if (j > 0)
            begin
                nl[i] = clean_seq[j-1];
                j--;
            end
            else
                i--;
        end
        // swap fix-up and fill
        for (k = 0; k < n; k++)
        begin
            if (k + 1 < n)
            begin
                a = tl[k+1];
                b = nl[k+1];
                if (a == b && b != ign_lbl && k + 2 <= n)
                begin
                    nl[k+1] = nl[k+2];
                    nl[k+2] = b;
                end
            end
            if (nl[k] == ign_lbl && (k == 0 || tl[k-1] != del_lbl))
            begin
                t = end_lbl;
                s = k;
                while (s < n && tl[s] == del_lbl) s++;
                if (s < n) t = tl[s];
                nl[k] = t;
            end
        end
        if (nl[n] == ign_lbl) nl[n] = end_lbl;
        for (k = 0; k <= n; k++)
        begin
            w.position        = eal_pkg::IDX_W'(k);
            w.has_token_label = (k < n);
            w.token_label     = (k < n) ? tl[k] : '0;
            w.next_label      = nl[k];
            w.last            = (k == n);
            label_q = {label_q, w};
        end
    endtask

    assign pending_words = label_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        label_word_t e;
        if (!rst_n)
        begin
            del_lbl    <= 32'hFFFF_FFFF;
            end_lbl    <= 32'hFFFF_FFFE;
            ign_lbl    <= 32'hFFFF_FF9C;
            keep_mode  <= 1'b0;
            noisy_cnt  <= 0;
            clean_cnt  <= 0;
            fail_count <= 0;
            words_seen <= 0;
            label_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (eal_pkg::reg_idx_t'(cfg_index))
                    eal_pkg::REG_DELETE: del_lbl   <= cfg_data;
                    eal_pkg::REG_END:    end_lbl   <= cfg_data;
                    eal_pkg::REG_IGNORE: ign_lbl   <= cfg_data;
                    eal_pkg::REG_KEEP:   keep_mode <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (command)
                    eal_pkg::CMD_NOISY:
                        if (noisy_cnt < eal_pkg::MAX_LEN)
                        begin
                            noisy_seq[noisy_cnt] = token;
                            noisy_cnt <= noisy_cnt + 1;
                        end
                    eal_pkg::CMD_CLEAN:
                        if (clean_cnt < eal_pkg::MAX_LEN)
                        begin
                            clean_seq[clean_cnt] = token;
                            clean_cnt <= clean_cnt + 1;
                        end
                    eal_pkg::CMD_RUN:
                    begin
                        predict_labels();
                        noisy_cnt <= 0;
                        clean_cnt <= 0;
                    end
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                words_seen <= words_seen + 1;
                if (label_q.size() == 0)
                begin
                    $error("unexpected result word at position %0d", position);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = label_q.pop_front();
                    if (position !== e.position || has_token_label !== e.has_token_label
                        || token_label !== e.token_label || next_label !== e.next_label
                        || last !== e.last)
                        fail_count <= fail_count + 1;
                    if (position !== e.position)
                        $error("position exp %0d got %0d", e.position, position);
                    if (has_token_label !== e.has_token_label)
                        $error("has_token_label exp %0b got %0b",
                               e.has_token_label, has_token_label);
                    if (token_label !== e.token_label)
                        $error("token_label exp %h got %h", e.token_label, token_label);
                    if (next_label !== e.next_label)
                        $error("next_label exp %h got %h", e.next_label, next_label);
                    if (last !== e.last)
                        $error("last exp %0b got %0b", e.last, last);
                end
            end
        end
    end

endmodule

### tb/sv/tb_edit_alignment_label_gen.sv
// tb_edit_alignment_label_gen: stimulus and verdict for the edit alignment label generator
// depends on eal_pkg, edit_alignment_label_gen and eal_label_checker
module tb_edit_alignment_label_gen;
    timeunit 1ns;
    timeprecision 1ps;

    // command code the block ignores
    localparam logic [1:0] CMD_BAD = 2'd3;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [1:0]                       command = eal_pkg::CMD_NOISY;
    logic signed [eal_pkg::TOK_W-1:0] token = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [eal_pkg::IDX_W-1:0]        position;
    logic                             has_token_label;
    logic signed [eal_pkg::TOK_W-1:0] token_label;
    logic signed [eal_pkg::TOK_W-1:0] next_label;
    logic                             last;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [eal_pkg::CFG_W-1:0]        cfg_index = eal_pkg::REG_DELETE;
    logic signed [eal_pkg::TOK_W-1:0] cfg_data = '0;
    int                               fail_count, pending_words, words_seen;
    int                               words_sent = 0;
    int                               runs_sent = 0;

    // small token alphabet makes keeps and collisions with labels common
    logic [eal_pkg::TOK_W-1:0]        alphabet[8];

    always #5 clk = ~clk;

    edit_alignment_label_gen i_dut (.*);

    eal_label_checker i_chk (.*);

    // mostly short gaps, now and then a long one, sometimes none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stall pattern, runs independently of the sender
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                out_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // one word on the input channel, with a random idle gap in front;
    // valid stays high after the accept so the next word can follow directly
    task automatic send_word(input logic [1:0] cmd, input logic [eal_pkg::TOK_W-1:0] tok);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        token    <= tok;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        if (cmd == eal_pkg::CMD_RUN) runs_sent++;
    endtask

    task automatic write_reg(input eal_pkg::reg_idx_t idx,
                             input logic [eal_pkg::TOK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // input goes idle, block is idle once every expected word is out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [eal_pkg::TOK_W-1:0] pick_token();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return alphabet[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // one sequence pair then a run; append order is interleaved at random
    task automatic send_run(input int n, input int m);
        int a, b;
        a = 0;
        b = 0;
        while (a < n || b < m)
        begin
            if (b >= m || (a < n && $urandom_range(0, 1)))
            begin
                send_word(eal_pkg::CMD_NOISY, pick_token());
                a++;
            end
            else
            begin
                send_word(eal_pkg::CMD_CLEAN, pick_token());
                b++;
            end
        end
        send_word(eal_pkg::CMD_RUN, $urandom());
    endtask

    function automatic int rand_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r < 17) return $urandom_range(1, 8);
        return $urandom_range(9, 20);
    endfunction

    task automatic set_labels(input logic [eal_pkg::TOK_W-1:0] d,
                              input logic [eal_pkg::TOK_W-1:0] e,
                              input logic [eal_pkg::TOK_W-1:0] ig, input logic kp);
        write_reg(eal_pkg::REG_DELETE, d);
        write_reg(eal_pkg::REG_END, e);
        write_reg(eal_pkg::REG_IGNORE, ig);
        write_reg(eal_pkg::REG_KEEP, {31'd0, kp});
    endtask

    initial
    begin
        int ph, r;
        alphabet = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'hFFFF_FF9C};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty runs, extremes, ignored command, label collisions
        send_word(eal_pkg::CMD_RUN, '0);
        send_word(eal_pkg::CMD_CLEAN, 32'h8000_0000);
        send_word(eal_pkg::CMD_RUN, '0);
        send_word(eal_pkg::CMD_NOISY, 32'h7FFF_FFFF);
        send_word(eal_pkg::CMD_NOISY, 32'hFFFF_FFFF);
        send_word(eal_pkg::CMD_CLEAN, 32'h7FFF_FFFF);
        send_word(eal_pkg::CMD_CLEAN, 32'hFFFF_FF9C);
        send_word(eal_pkg::CMD_CLEAN, 32'h5555_5555);
        send_word(CMD_BAD, 32'hAAAA_AAAA);
        send_word(eal_pkg::CMD_RUN, 32'hFFFF_FFFF);
        send_word(eal_pkg::CMD_NOISY, 32'h1);
        send_word(eal_pkg::CMD_NOISY, 32'h2);
        send_word(eal_pkg::CMD_CLEAN, 32'h2);
        send_word(eal_pkg::CMD_CLEAN, 32'h1);
        send_word(eal_pkg::CMD_RUN, '0);
        drain();
        set_labels(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
        send_run(3, 5);
        drain();
        // full sequences with overflow appends ignored
        set_labels(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_run(eal_pkg::MAX_LEN + 1, eal_pkg::MAX_LEN + 1);
        drain();

        // random phases, each with its own label setting
        for (ph = 0; ph < 6; ph++)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                set_labels($urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
            else if (r == 1)
                set_labels(alphabet[$urandom_range(0, 7)], alphabet[$urandom_range(0, 7)],
                           alphabet[$urandom_range(0, 7)], 1'($urandom_range(0, 1)));
            else
                set_labels(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FF9C, ph[0]);
            while (words_sent < 120 + ph * 60)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_word(CMD_BAD, $urandom());
                else
                    send_run(rand_len(), rand_len());
            end
            drain();
        end

        repeat (200) @(posedge clk);
        $display("sent %0d input words in %0d runs, checked %0d result words",
                 words_sent, runs_sent, words_seen);
        if (fail_count == 0 && pending_words == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
hdl/eal_pkg.sv
hdl/eal_ctrl.sv
hdl/eal_dp.sv
hdl/edit_alignment_label_gen.sv
tb/sv/eal_label_checker.sv
tb/sv/tb_edit_alignment_label_gen.sv
